/* hw/rtl/bpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIME_W      = 32;
    localparam int DUR_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_DEBOUNCE = 2'd1,
        ST_PRESSED  = 2'd2,
        ST_HOLDING  = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_SHORT   = 2'd1,
        EV_LONG    = 2'd2,
        EV_HOLDING = 2'd3
    } event_t;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_FETCH  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 8'd3;

    localparam logic             RST_ACTIVE_LEVEL    = 1'b0;
    localparam logic [DUR_W-1:0] RST_DEBOUNCE_TIME   = 16'd20;
    localparam logic [DUR_W-1:0] RST_LONG_PRESS_TIME = 16'd800;
    localparam logic [DUR_W-1:0] RST_REPEAT_INTERVAL = 16'd100;

    typedef struct packed {
        logic             active_level;
        logic [DUR_W-1:0] debounce_time;
        logic [DUR_W-1:0] long_press_time;
        logic [DUR_W-1:0] repeat_interval;
    } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/button_press_classifier_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Debounce, long-press and repeat classifier for one push button.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then its result is
//   stored in the result register once that register is free.
// Throughput: one item per cycle while m_ready is high; the state update is
//   a 32-bit subtract and compare between the input and result registers.
// Reset: synchronous, active low; state idle, timers zero, no event latched,
//   registers at active_level 0, debounce 20, long press 800, repeat 100.
// ----------------------------------------------------------------------------
module button_press_classifier_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic                             s_pin_level,
    input  wire logic [bpc_pkg::TIME_W-1:0]       s_now_ms,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_event_code,
    output logic [1:0]                            m_press_state,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bpc_pkg::cfg_t               cfg;
    logic                        in_valid_reg;
    logic                        in_func_reg;
    logic                        in_pin_reg;
    logic [bpc_pkg::TIME_W-1:0]  in_now_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_event_reg;
    logic [1:0]                  out_state_reg;
    logic                        step_en;
    logic                        in_load;
    logic [1:0]                  event_code;
    logic [1:0]                  press_state;

    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .func        (in_func_reg),
        .pin_level   (in_pin_reg),
        .now_ms      (in_now_reg),
        .cfg         (cfg),
        .event_code  (event_code),
        .press_state (press_state)
    );

    // advance the held item when the result register is free
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign in_load = s_valid && s_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_en)      out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_load || (in_valid_reg && !step_en);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_func_reg <= s_func;
            in_pin_reg  <= s_pin_level;
            in_now_reg  <= s_now_ms;
        end
        if (step_en) begin
            out_event_reg <= event_code;
            out_state_reg <= press_state;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_code  = out_event_reg;
    assign m_press_state = out_state_reg;

endmodule
`default_nettype wire

/* hw/rtl/bpc_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bpc_pkg::cfg_t                         cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bpc_pkg::REG_ACTIVE_LEVEL:    cfg_next.active_level    = cfg_data[0];
                bpc_pkg::REG_DEBOUNCE_TIME:   cfg_next.debounce_time   = cfg_data;
                bpc_pkg::REG_LONG_PRESS_TIME: cfg_next.long_press_time = cfg_data;
                bpc_pkg::REG_REPEAT_INTERVAL: cfg_next.repeat_interval = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level    <= bpc_pkg::RST_ACTIVE_LEVEL;
            cfg_reg.debounce_time   <= bpc_pkg::RST_DEBOUNCE_TIME;
            cfg_reg.long_press_time <= bpc_pkg::RST_LONG_PRESS_TIME;
            cfg_reg.repeat_interval <= bpc_pkg::RST_REPEAT_INTERVAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bpc_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_classify
// Press state machine, phase timers and latched event.
// ----------------------------------------------------------------------------
module bpc_classify (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire logic                         func,
    input  wire logic                         pin_level,
    input  wire logic [bpc_pkg::TIME_W-1:0]   now_ms,
    input  wire bpc_pkg::cfg_t                cfg,
    output logic [1:0]                        event_code,
    output logic [1:0]                        press_state
);

    bpc_pkg::state_t             state_reg,   state_next;
    bpc_pkg::event_t             pending_reg, pending_next;
    logic [bpc_pkg::TIME_W-1:0]  phase_reg,   phase_next;
    logic [bpc_pkg::TIME_W-1:0]  repeat_reg,  repeat_next;
    logic [bpc_pkg::TIME_W-1:0]  phase_elapsed;
    logic [bpc_pkg::TIME_W-1:0]  repeat_elapsed;
    logic                        pressed;
    logic                        update;
    logic                        debounce_done;
    logic                        long_done;
    logic                        repeat_done;

    assign pressed        = (pin_level == cfg.active_level);
    assign update         = step_en && (func == bpc_pkg::FUNC_UPDATE);
    assign phase_elapsed  = now_ms - phase_reg;
    assign repeat_elapsed = now_ms - repeat_reg;
    assign debounce_done  = phase_elapsed >=
                            {{(bpc_pkg::TIME_W-bpc_pkg::DUR_W){1'b0}}, cfg.debounce_time};
    assign long_done      = phase_elapsed >=
                            {{(bpc_pkg::TIME_W-bpc_pkg::DUR_W){1'b0}}, cfg.long_press_time};
    assign repeat_done    = repeat_elapsed >=
                            {{(bpc_pkg::TIME_W-bpc_pkg::DUR_W){1'b0}}, cfg.repeat_interval};

    // next state
    always_comb begin
        state_next = state_reg;
        if (update) begin
            unique case (state_reg)
                bpc_pkg::ST_IDLE: begin
                    if (pressed) state_next = bpc_pkg::ST_DEBOUNCE;
                end
                bpc_pkg::ST_DEBOUNCE: begin
                    if (!pressed)          state_next = bpc_pkg::ST_IDLE;
                    else if (debounce_done) state_next = bpc_pkg::ST_PRESSED;
                end
                bpc_pkg::ST_PRESSED: begin
                    if (!pressed)      state_next = bpc_pkg::ST_IDLE;
                    else if (long_done) state_next = bpc_pkg::ST_HOLDING;
                end
                bpc_pkg::ST_HOLDING: begin
                    if (!pressed) state_next = bpc_pkg::ST_IDLE;
                end
                default: state_next = bpc_pkg::ST_IDLE;
            endcase
        end
    end

    // outputs, timers and latched event
    always_comb begin
        phase_next   = phase_reg;
        repeat_next  = repeat_reg;
        pending_next = pending_reg;
        event_code   = bpc_pkg::EV_NONE;
        if (step_en && (func == bpc_pkg::FUNC_FETCH)) begin
            event_code   = pending_reg;
            pending_next = bpc_pkg::EV_NONE;
        end else if (update) begin
            unique case (state_reg)
                bpc_pkg::ST_IDLE: begin
                    if (pressed) phase_next = now_ms;
                end
                bpc_pkg::ST_DEBOUNCE: begin
                    if (pressed && debounce_done) phase_next = now_ms;
                end
                bpc_pkg::ST_PRESSED: begin
                    if (!pressed) begin
                        pending_next = bpc_pkg::EV_SHORT;
                    end else if (long_done) begin
                        pending_next = bpc_pkg::EV_LONG;
                        repeat_next  = now_ms;
                    end
                end
                bpc_pkg::ST_HOLDING: begin
                    if (pressed && repeat_done) begin
                        pending_next = bpc_pkg::EV_HOLDING;
                        repeat_next  = now_ms;
                    end
                end
                default: ;
            endcase
        end
    end

    assign press_state = state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpc_pkg::ST_IDLE;
            pending_reg <= bpc_pkg::EV_NONE;
            phase_reg   <= '0;
            repeat_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            repeat_reg  <= repeat_next;
        end
    end

`ifndef ASSERT_OFF
    a_idle_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpc_pkg::ST_IDLE |=>
            (state_reg == bpc_pkg::ST_IDLE || state_reg == bpc_pkg::ST_DEBOUNCE))
        else $error("idle left for a state other than debounce");

    a_fetch_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && func == bpc_pkg::FUNC_FETCH |=> pending_reg == bpc_pkg::EV_NONE)
        else $error("latched event survived a fetch");

    a_fetch_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && func == bpc_pkg::FUNC_FETCH |=> $stable(state_reg))
        else $error("fetch moved the state machine");

    a_long_into_holding: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpc_pkg::ST_PRESSED ##1 state_reg == bpc_pkg::ST_HOLDING |->
            pending_reg == bpc_pkg::EV_LONG)
        else $error("holding entered without a long press event");
`endif

endmodule
`default_nettype wire
